FILE: hw/rtl/pmws_pkg.sv
// ----------------------------------------------------------------------------
// pmws_pkg: shared types and constants of the motif window scorer
// Field widths, command codes, letter decode and the cell control word.
// ----------------------------------------------------------------------------
package pmws_pkg;

    // Field widths
    localparam int SCORE_W    = 21;
    localparam int WEIGHT_W   = 16;
    localparam int CHAR_W     = 8;
    localparam int POS_W      = 5;
    localparam int LETTER_W   = 2;
    localparam int CMD_W      = 2;
    localparam int LEN_W      = 6;
    localparam int NUM_LETTERS = 4;

    // Chain length default and register reset
    localparam int MAX_LEN_DEF = 32;
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd8;

    // Register bus
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_MOTIF_LENGTH = 1'b0;

    // Sequence characters
    localparam logic [CHAR_W-1:0] CHAR_A_UP = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_A_LO = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_C_LO = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_T_UP = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_T_LO = 8'h74;

    // Letter column codes
    localparam logic [LETTER_W-1:0] LET_A = 2'd0;
    localparam logic [LETTER_W-1:0] LET_C = 2'd1;
    localparam logic [LETTER_W-1:0] LET_G = 2'd2;
    localparam logic [LETTER_W-1:0] LET_T = 2'd3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_SCAN    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    typedef struct packed {
        logic                hit;
        logic [LETTER_W-1:0] code;
    } t_letter;

    // Control word broadcast to every cell
    typedef struct packed {
        logic                       scan;
        logic                       clear;
        logic                       hit;
        logic [LETTER_W-1:0]        letter;
        logic [LETTER_W-1:0]        load_letter;
        logic signed [WEIGHT_W-1:0] load_value;
    } t_cell_ctrl;

    // Map an ASCII byte to its letter column; other bytes miss
    function automatic t_letter letter_of(input logic [CHAR_W-1:0] ch);
        t_letter res;
        res.hit  = 1'b1;
        res.code = LET_A;
        unique case (ch)
            CHAR_A_UP, CHAR_A_LO: res.code = LET_A;
            CHAR_C_UP, CHAR_C_LO: res.code = LET_C;
            CHAR_G_UP, CHAR_G_LO: res.code = LET_G;
            CHAR_T_UP, CHAR_T_LO: res.code = LET_T;
            default:              res.hit  = 1'b0;
        endcase
        return res;
    endfunction

endpackage

FILE: hw/rtl/pmws_cell.sv
// ----------------------------------------------------------------------------
// pmws_cell: one matrix position of the scoring chain
// Holds the four letter weights of its position and the partial sum of the
// window ending at the latest base; takes its left neighbor's sum every scan.
// ----------------------------------------------------------------------------
module pmws_cell
    import pmws_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cell_ctrl                i_ctrl,
    input  logic                      i_load_en,
    input  logic signed [SCORE_W-1:0] i_prev_sum,
    output logic signed [SCORE_W-1:0] o_sum,
    output logic signed [SCORE_W-1:0] o_scan_sum
);

    logic signed [WEIGHT_W-1:0] r_weight [NUM_LETTERS];
    logic signed [SCORE_W-1:0]  r_sum;
    logic signed [SCORE_W-1:0]  n_sum;
    logic signed [SCORE_W-1:0]  w_add;

    // Write one weight column on a load word
    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_weight[i_ctrl.load_letter] <= i_ctrl.load_value;
        end
    end

    // Add this position's weight to the sum handed over from the left
    assign w_add      = i_ctrl.hit ? SCORE_W'(r_weight[i_ctrl.letter]) : '0;
    assign o_scan_sum = i_prev_sum + w_add;

    always_comb begin
        n_sum = r_sum;
        if (i_ctrl.clear) begin
            n_sum = '0;
        end else if (i_ctrl.scan) begin
            n_sum = o_scan_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

FILE: hw/rtl/pmws_skid.sv
// ----------------------------------------------------------------------------
// pmws_skid: two-entry result buffer
// Output register plus one skid entry, so the input side keeps taking words
// while a finished score waits for the receiver.
// ----------------------------------------------------------------------------
module pmws_skid #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    input  logic         i_stall
);

    logic         r_out_valid;
    logic         n_out_valid;
    logic [W-1:0] r_out_data;
    logic         r_skid_valid;
    logic         n_skid_valid;
    logic [W-1:0] r_skid_data;
    logic         w_out_free;

    // Output slot frees when empty or when its word leaves this cycle
    assign w_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (w_out_free) begin
            n_out_valid  = r_skid_valid || i_push;
            n_skid_valid = 1'b0;
        end else if (i_push) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Move payload: skid entry drains first, else take the new word
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_push) begin
            r_skid_data <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

FILE: hw/rtl/pwm_motif_window_scorer_core.sv
// ----------------------------------------------------------------------------
// pwm_motif_window_scorer_core: DNA stream scan with a position weight matrix
// Input words carry a command: load one weight, scan one base, or restart.
// A chain of MAX_LEN cells keeps one partial sum per matrix position and
// shifts every sum one cell to the right on each scanned base.
//
// Input channel: i_in_valid / o_in_stall; a word is taken when valid is high
// and stall is low. One word per cycle is taken back to back while stall stays
// low; a scan or restart updates every cell, a load one cell, as it is taken.
// Output channel: o_out_valid / i_out_stall; one window score for each scanned
// base once motif_length (clamped to 1..MAX_LEN) bases have arrived since the
// last restart. A score is registered into the output register or skid entry.
// A two-entry output buffer lets input flow on while a score waits; o_in_stall
// rises only when both entries hold a score the receiver has not taken.
// Reset clears the partial sums, the base count and the output buffer and sets
// motif_length to 8. Weights are not cleared: load each one before scanning.
// Write motif_length over the APB port only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module pwm_motif_window_scorer_core
    import pmws_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input words
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [CMD_W-1:0]             i_command,
    input  logic [CHAR_W-1:0]            i_base_char,
    input  logic [POS_W-1:0]             i_weight_position,
    input  logic [LETTER_W-1:0]          i_weight_letter,
    input  logic signed [WEIGHT_W-1:0]   i_weight_value,
    // Result words
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [SCORE_W-1:0]    o_window_score,
    // Register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [LEN_W-1:0]          r_motif_length;
    logic [CNT_W-1:0]          r_seen;
    logic [CNT_W-1:0]          n_seen;
    logic [CNT_W-1:0]          w_seen_inc;
    logic [CNT_W-1:0]          w_width;
    logic [IDX_W-1:0]          w_sel;
    logic                      w_in_accept;
    logic                      w_is_load;
    logic                      w_is_scan;
    logic                      w_is_restart;
    logic                      w_push;
    logic                      w_full;
    logic [SCORE_W-1:0]        w_buf_data;
    t_letter                   w_letter;
    t_cell_ctrl                w_ctrl;
    logic signed [SCORE_W-1:0] w_sum      [MAX_LEN];
    logic signed [SCORE_W-1:0] w_scan_sum [MAX_LEN];
    logic                      w_cfg_wr;

    // Register port: one register, zero-wait
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motif_length <= LEN_RESET;
        end else if (w_cfg_wr && (paddr[2:2] == REG_MOTIF_LENGTH)) begin
            r_motif_length <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2:2] == REG_MOTIF_LENGTH) ? APB_DATA_W'(r_motif_length) : '0;

    // Decode the command of the word being taken
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_comb begin
        w_is_load    = 1'b0;
        w_is_scan    = 1'b0;
        w_is_restart = 1'b0;
        unique case (t_cmd'(i_command))
            CMD_LOAD:    w_is_load    = w_in_accept;
            CMD_SCAN:    w_is_scan    = w_in_accept;
            CMD_RESTART: w_is_restart = w_in_accept;
            default: ;
        endcase
    end

    assign w_letter = letter_of(i_base_char);

    always_comb begin
        w_ctrl.scan        = w_is_scan;
        w_ctrl.clear       = w_is_restart;
        w_ctrl.hit         = w_letter.hit;
        w_ctrl.letter      = w_letter.code;
        w_ctrl.load_letter = i_weight_letter;
        w_ctrl.load_value  = i_weight_value;
    end

    // Chain of cells, one per matrix position
    for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
        logic                      w_load_en;
        logic signed [SCORE_W-1:0] w_prev;

        assign w_load_en = w_is_load && (32'(i_weight_position) == 32'(gi));

        if (gi == 0) begin : g_head
            assign w_prev = '0;
        end else begin : g_link
            assign w_prev = w_sum[gi-1];
        end

        pmws_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_load_en  (w_load_en),
            .i_prev_sum (w_prev),
            .o_sum      (w_sum[gi]),
            .o_scan_sum (w_scan_sum[gi])
        );
    end

    // Window width in use, clamped to 1..MAX_LEN
    always_comb begin
        if (r_motif_length == '0) begin
            w_width = CNT_W'(1);
        end else if (int'(r_motif_length) > MAX_LEN) begin
            w_width = CNT_W'(MAX_LEN);
        end else begin
            w_width = CNT_W'(r_motif_length);
        end
    end

    assign w_sel = IDX_W'(w_width - CNT_W'(1));

    // Count bases since restart, saturating at the chain length
    assign w_seen_inc = (int'(r_seen) < MAX_LEN) ? r_seen + CNT_W'(1) : r_seen;

    always_comb begin
        n_seen = r_seen;
        if (w_is_restart) begin
            n_seen = '0;
        end else if (w_is_scan) begin
            n_seen = w_seen_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else begin
            r_seen <= n_seen;
        end
    end

    // Emit the full-window score once enough bases are in
    assign w_push = w_is_scan && (w_seen_inc >= w_width);

    pmws_skid #(
        .W (SCORE_W)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_scan_sum[w_sel]),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .o_data  (w_buf_data),
        .i_stall (i_out_stall)
    );

    assign o_in_stall     = w_full;
    assign o_window_score = w_buf_data;

endmodule

FILE: hw/rtl/pmws_checker.sv
// ----------------------------------------------------------------------------
// pmws_checker: port-level checks for the motif window scorer
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module pmws_checker
    import pmws_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic [CMD_W-1:0]           i_command,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [SCORE_W-1:0]  o_window_score
);

    // A stalled score holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_window_score))
        else $error("stalled score changed or dropped");

    // Input stalls only while a score is waiting
    a_stall_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // Reset empties the result buffer
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result pending after reset");

    // Loads and restarts make no score
    a_no_score_for_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_command != CMD_SCAN) && !o_out_valid
        |=> !o_out_valid)
        else $error("score from a non-scan word");

endmodule

bind pwm_motif_window_scorer_core pmws_checker u_pmws_checker (.*);
